[src/gps_pkg.sv]
// Shared types and constants for the grinder purge sequencer.
// No dependencies; used by every file under src.
package gps_pkg;

  // Tick counter width as seen by the sequencer (default for the top level).
  localparam int unsigned TICK_BITS_DEF = 32;

  // Payload and configuration widths.
  localparam int unsigned NOW_W   = 32;
  localparam int unsigned CODE_W  = 8;
  localparam int unsigned CFG_W   = 20;
  localparam int unsigned CFG_IDX_W = 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_LOADING = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RUN     = 1'd1;

  // Configuration reset values.
  localparam logic [CFG_W-1:0] LOADING_RST = 20'd10000;
  localparam logic [CFG_W-1:0] RUN_RST     = 20'd5000;

  // Input codes with a meaning.
  localparam logic [CODE_W-1:0] ABLE_TO_CLEAR = 8'd2;
  localparam logic [CODE_W-1:0] HANDLE_SEATED = 8'd1;

  typedef enum logic [2:0] {
    STEP_NONE  = 3'd0,
    STEP_HINT  = 3'd1,
    STEP_DELAY = 3'd2,
    STEP_WAIT  = 3'd3,
    STEP_RUN   = 3'd4,
    STEP_DONE  = 3'd5
  } step_e;

  typedef enum logic [1:0] {
    VOICE_NONE   = 2'd0,
    VOICE_UNLOCK = 2'd1,
    VOICE_HANDLE = 2'd2,
    VOICE_CHIME  = 2'd3
  } voice_e;

  // Control state of the sequence (tick stamp is kept apart, its width varies).
  typedef struct packed {
    logic  active;
    step_e step;
    logic  grinder_on;
  } seq_state_t;

  // One result of a control-loop pass.
  typedef struct packed {
    logic   next_mode;
    logic   grind_start;
    logic   grind_stop;
    voice_e voice;
    logic   clear_keys;
    step_e  step_now;
  } seq_res_t;

endpackage

[src/gps_core.sv]
// Next-state and result logic for one pass of the purge sequence.
// Depends on gps_pkg.
module gps_core #(
  parameter int unsigned TICK_BITS = gps_pkg::TICK_BITS_DEF
) (
  input  gps_pkg::seq_state_t               state_i,
  input  logic [TICK_BITS-1:0]              step_start_i,
  input  logic [TICK_BITS-1:0]              cur_tick_i,
  input  logic [gps_pkg::CODE_W-1:0]        bin_status_i,
  input  logic [gps_pkg::CODE_W-1:0]        handle_flag_i,
  input  logic [gps_pkg::CODE_W-1:0]        fault_code_i,
  input  logic                              water_short_i,
  input  logic                              voice_busy_i,
  input  logic [gps_pkg::CFG_W-1:0]         loading_ticks_i,
  input  logic [gps_pkg::CFG_W-1:0]         run_ticks_i,
  output gps_pkg::seq_state_t               state_o,
  output logic [TICK_BITS-1:0]              step_start_o,
  output gps_pkg::seq_res_t                 res_o
);

  localparam int unsigned CMP_W = (TICK_BITS > gps_pkg::CFG_W) ? TICK_BITS : gps_pkg::CFG_W;

  gps_pkg::seq_state_t  st;
  gps_pkg::seq_res_t    res;
  logic [TICK_BITS-1:0] start;
  logic [CMP_W-1:0]     elapsed;
  logic                 handle;
  logic                 abort;
  logic                 go_en;
  gps_pkg::step_e       go_step;

  always_comb begin
    st      = state_i;
    start   = step_start_i;
    abort   = 1'b0;
    go_en   = 1'b0;
    go_step = gps_pkg::STEP_NONE;
    handle  = (handle_flag_i == gps_pkg::HANDLE_SEATED);

    res             = '0;
    res.next_mode   = 1'b1;
    res.clear_keys  = 1'b1;
    res.voice       = gps_pkg::VOICE_NONE;

    // Fresh sequence: arm it and stamp the current tick.
    if (!st.active) begin
      st.active = 1'b1;
      st.step   = gps_pkg::STEP_NONE;
      start     = cur_tick_i;
    end

    elapsed = CMP_W'(cur_tick_i - start);

    if (fault_code_i != '0 || water_short_i || bin_status_i != gps_pkg::ABLE_TO_CLEAR) begin
      abort = 1'b1;
    end else if (st.step == gps_pkg::STEP_NONE) begin
      go_en     = 1'b1;
      go_step   = gps_pkg::STEP_HINT;
      res.voice = gps_pkg::VOICE_UNLOCK;
    end else if (st.step == gps_pkg::STEP_HINT) begin
      go_en   = 1'b1;
      go_step = gps_pkg::STEP_DELAY;
    end else if (st.step == gps_pkg::STEP_DELAY &&
                 elapsed < CMP_W'(loading_ticks_i)) begin
      // hold in delay
    end else if (!handle) begin
      res.grind_stop = st.grinder_on;
      st.grinder_on  = 1'b0;
      go_en          = 1'b1;
      go_step        = gps_pkg::STEP_WAIT;
      res.voice      = gps_pkg::VOICE_HANDLE;
    end else if (st.step != gps_pkg::STEP_RUN && st.step != gps_pkg::STEP_DONE) begin
      if (!voice_busy_i && !st.grinder_on) begin
        res.grind_start = 1'b1;
        st.grinder_on   = 1'b1;
        go_en           = 1'b1;
        go_step         = gps_pkg::STEP_RUN;
      end
    end else if (st.step == gps_pkg::STEP_RUN && elapsed >= CMP_W'(run_ticks_i)) begin
      res.grind_stop = st.grinder_on;
      st.grinder_on  = 1'b0;
      go_en          = 1'b1;
      go_step        = gps_pkg::STEP_DONE;
      res.voice      = gps_pkg::VOICE_CHIME;
    end else if (st.step == gps_pkg::STEP_DONE && !voice_busy_i) begin
      abort = 1'b1;
    end

    // Restamp only on a real step change.
    if (go_en && st.step != go_step) begin
      st.step = go_step;
      start   = cur_tick_i;
    end

    if (abort) begin
      res.grind_stop = st.grinder_on;
      st.grinder_on  = 1'b0;
      st.step        = gps_pkg::STEP_NONE;
      st.active      = 1'b0;
      start          = '0;
      res.next_mode  = 1'b0;
      res.clear_keys = 1'b0;
      res.voice      = gps_pkg::VOICE_NONE;
    end

    res.step_now = st.step;
  end

  assign state_o      = st;
  assign step_start_o = start;
  assign res_o        = res;

endmodule

[src/grinder_purge_sequencer_top.sv]
// Top level of the grinder purge sequencer: request register, sequence
// state, result register and configuration registers. Depends on gps_pkg, gps_core.
//
// Usage:
//   Each request on the in_* channel is one pass of the control loop while a
//   bean-hopper purge runs. The block answers every request with exactly one
//   result on the out_* channel, in order.
// Flow:
//   A request accepted at one clock edge sits in the request register; once
//   the result register is free or draining, the sequence logic runs and
//   loads the result into the result register, which drives out_valid_o.
//   One request per cycle is sustained while out_ready_i is high: the state
//   loops through gps_core, and in_ready_o stays high while the result moves.
// Stall:
//   With out_ready_i low the result holds; one more request waits in the
//   request register, then in_ready_o drops until the receiver drains.
// Reset:
//   rst_ni low clears both valid flags and the sequence state (inactive, step
//   none, grinder off, stamp zero) and loads the default loading and run
//   periods. Configuration writes take effect at the edge with cfg_we_i high.
module grinder_purge_sequencer_top #(
  parameter int unsigned TICK_BITS = gps_pkg::TICK_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration port
  input  logic                          cfg_we_i,
  input  logic [gps_pkg::CFG_IDX_W-1:0] cfg_addr_i,
  input  logic [gps_pkg::CFG_W-1:0]     cfg_wdata_i,
  // request channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [gps_pkg::NOW_W-1:0]     now_tick_i,
  input  logic [gps_pkg::CODE_W-1:0]    bin_status_i,
  input  logic [gps_pkg::CODE_W-1:0]    handle_flag_i,
  input  logic [gps_pkg::CODE_W-1:0]    fault_code_i,
  input  logic                          water_short_i,
  input  logic                          voice_busy_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          next_mode_o,
  output logic                          grind_start_o,
  output logic                          grind_stop_o,
  output logic [1:0]                    voice_request_o,
  output logic                          clear_keys_o,
  output logic [2:0]                    step_now_o
);

  // configuration registers
  logic [gps_pkg::CFG_W-1:0] loading_q, run_q;

  // request register
  logic                       in_vld_q, in_vld_d;
  logic [gps_pkg::NOW_W-1:0]  now_q;
  logic [gps_pkg::CODE_W-1:0] bin_q, handle_q, fault_q;
  logic                       water_q, busy_q;

  // sequence state
  gps_pkg::seq_state_t  state_q, state_d;
  logic [TICK_BITS-1:0] start_q, start_d;

  // result register
  logic              out_vld_q, out_vld_d;
  gps_pkg::seq_res_t res_q, res_d;

  logic in_take;
  logic advance;

  // Advance when a request is held and the result slot is free or draining.
  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;
  assign in_take    = in_valid_i && in_ready_o;
  assign in_vld_d   = in_take || (in_vld_q && !advance);
  assign out_vld_d  = advance || (out_vld_q && !out_ready_i);

  gps_core #(
    .TICK_BITS (TICK_BITS)
  ) u_core (
    .state_i         (state_q),
    .step_start_i    (start_q),
    .cur_tick_i      (TICK_BITS'(now_q)),
    .bin_status_i    (bin_q),
    .handle_flag_i   (handle_q),
    .fault_code_i    (fault_q),
    .water_short_i   (water_q),
    .voice_busy_i    (busy_q),
    .loading_ticks_i (loading_q),
    .run_ticks_i     (run_q),
    .state_o         (state_d),
    .step_start_o    (start_d),
    .res_o           (res_d)
  );

  // Configuration writes: no wait, no read-back.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loading_q <= gps_pkg::LOADING_RST;
      run_q     <= gps_pkg::RUN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        gps_pkg::REG_LOADING: loading_q <= cfg_wdata_i;
        gps_pkg::REG_RUN:     run_q     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Control: valid flags and sequence state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      state_q   <= '{active: 1'b0, step: gps_pkg::STEP_NONE, grinder_on: 1'b0};
      start_q   <= '0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      if (advance) begin
        state_q <= state_d;
        start_q <= start_d;
      end
    end
  end

  // Payload: capture the request, load the result.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      now_q    <= now_tick_i;
      bin_q    <= bin_status_i;
      handle_q <= handle_flag_i;
      fault_q  <= fault_code_i;
      water_q  <= water_short_i;
      busy_q   <= voice_busy_i;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign next_mode_o     = res_q.next_mode;
  assign grind_start_o   = res_q.grind_start;
  assign grind_stop_o    = res_q.grind_stop;
  assign voice_request_o = res_q.voice;
  assign clear_keys_o    = res_q.clear_keys;
  assign step_now_o      = res_q.step_now;

endmodule

[src/gps_checker.sv]
// Port-level checks for the grinder purge sequencer, bound to the top level.
// Depends on gps_pkg and grinder_purge_sequencer_top.
module gps_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          cfg_we_i,
  input logic [gps_pkg::CFG_IDX_W-1:0] cfg_addr_i,
  input logic [gps_pkg::CFG_W-1:0]     cfg_wdata_i,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic [gps_pkg::NOW_W-1:0]     now_tick_i,
  input logic [gps_pkg::CODE_W-1:0]    bin_status_i,
  input logic [gps_pkg::CODE_W-1:0]    handle_flag_i,
  input logic [gps_pkg::CODE_W-1:0]    fault_code_i,
  input logic                          water_short_i,
  input logic                          voice_busy_i,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic                          next_mode_o,
  input logic                          grind_start_o,
  input logic                          grind_stop_o,
  input logic [1:0]                    voice_request_o,
  input logic                          clear_keys_o,
  input logic [2:0]                    step_now_o
);

  // A stalled result holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(step_now_o) &&
      $stable(next_mode_o) && $stable(grind_start_o) && $stable(grind_stop_o))
    else $error("result changed while stalled");

  // Start and stop never pulse together.
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(grind_start_o && grind_stop_o))
    else $error("grinder start and stop in one result");

  // Return to ready clears step, voice and key flag; staying keeps keys cleared.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (next_mode_o == clear_keys_o) &&
      (next_mode_o || (step_now_o == gps_pkg::STEP_NONE &&
                       voice_request_o == gps_pkg::VOICE_NONE)))
    else $error("inconsistent return to ready");

  // A start pulse lands in the running step.
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && grind_start_o |-> next_mode_o && step_now_o == gps_pkg::STEP_RUN)
    else $error("grinder start outside running step");

endmodule

bind grinder_purge_sequencer_top gps_checker u_gps_checker (.*);
